// ===== design/frb_pkg.sv =====
// ---------------------------------------------------------------------------
// frb_pkg: fragment reassembly buffer shared types and constants
// Status codes, controller states, key result bundle and default sizes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package frb_pkg;

  localparam int unsigned DEF_SLOTS     = 16;
  localparam int unsigned DEF_MSG_BYTES = 1024;
  localparam int unsigned KEY_W         = 32;
  localparam int unsigned FLEN_W        = 11;
  localparam int unsigned OLEN_W        = 11;
  localparam logic [10:0] MAX_PAYLOAD_RST = 11'd1024;
  // ceil(2^37 / 100): exact unsigned 32-bit divide by 100 after >> 37
  localparam logic [31:0] RECIP_100     = 32'h51EB_851F;
  localparam int unsigned RECIP_SHIFT   = 37;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_MSG_FULL  = 3'd3,
    ST_BYTE_READ = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY1,
    S_KEY2,
    S_EXEC,
    S_RD,
    S_RDD
  } ctl_state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] group;   // key / 100
  } key_res_t;

endpackage
`default_nettype wire

// ===== design/frb_key_unit.sv =====
// ---------------------------------------------------------------------------
// frb_key_unit: message key and group pipeline
// Stage 1 forms 100*(src*13+dest*7+seqno)+link, stage 2 divides it by 100.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module frb_key_unit
  import frb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [15:0] src,
  input  wire logic [15:0] dest,
  input  wire logic [15:0] seqno,
  input  wire logic [4:0]  link,
  output key_res_t         res
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] group_r, group_nxt;
  logic [20:0]      h;
  logic [63:0]      prod;

  always_comb begin
    h         = 21'(src) * 21'd13 + 21'(dest) * 21'd7 + 21'(seqno);
    key_nxt   = 32'(h) * 32'd100 + 32'(link);
    prod      = 64'(key_r) * 64'(RECIP_100);
    group_nxt = 32'(prod >> RECIP_SHIFT);
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    group_r <= group_nxt;
  end

  // group_r is computed from key_r and registered in the cycle after it; the controller samples both after stage 2
  assign res.key   = key_r;
  assign res.group = group_r;

endmodule
`default_nettype wire

// ===== design/frb_payload_ram.sv =====
// ---------------------------------------------------------------------------
// frb_payload_ram: payload byte store
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module frb_payload_ram #(
  parameter int unsigned ADDR_W = 14
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic [7:0]             rdata
);

  logic [7:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/fragment_reassembly_buffer_core.sv =====
// ---------------------------------------------------------------------------
// fragment_reassembly_buffer_core: message fragment reassembly buffer
// Slot table with parallel key match and a shared payload RAM.
// ---------------------------------------------------------------------------
// One item is handled at a time. A save item passes the two key pipeline
// stages and then one table update before its result is presented; a fetch
// byte passes the key stages, table lookup, RAM read and registered read data,
// and a fetch that finds no slot or an empty message is answered after the
// table lookup. The next item is accepted the cycle after the result has been
// taken. The slot table (valid, key, group, length) sits in flops and is
// matched in parallel; payload bytes live in a SLOTS*MSG_BYTES synchronous
// RAM. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module fragment_reassembly_buffer_core
  import frb_pkg::*;
#(
  parameter int unsigned SLOTS     = DEF_SLOTS,
  parameter int unsigned MSG_BYTES = DEF_MSG_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // src[15:0], dest[31:16], seqno[47:32], link[52:48], frag_length[63:53],
  // data_byte[71:64]
  input  wire logic [71:0] in_tdata,
  // op[0]
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[2:0], out_byte[10:3], total_len[21:11], zero[23:22]
  output logic [23:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data
);

  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned BYTE_W = $clog2(MSG_BYTES);
  localparam int unsigned LEN_W  = $clog2(MSG_BYTES + 1);
  localparam int unsigned ADDR_W = SLOT_W + BYTE_W;
  localparam logic [LEN_W-1:0] MSG_MAX = LEN_W'(MSG_BYTES);

  ctl_state_t state_r, state_nxt;

  logic [10:0] max_payload_r;

  // latched item
  logic              op_r;
  logic [15:0]       src_r, dest_r, seqno_r;
  logic [4:0]        link_r;
  logic [FLEN_W-1:0] flen_r;
  logic [7:0]        dbyte_r;

  // slot table
  logic [SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  logic [KEY_W-1:0] slot_key_r   [SLOTS];
  logic [KEY_W-1:0] slot_group_r [SLOTS];
  logic [LEN_W-1:0] slot_len_r   [SLOTS];

  logic              frag_active_r, frag_active_nxt;
  logic [SLOT_W-1:0] frag_slot_r, frag_slot_nxt;
  logic [FLEN_W-1:0] frag_left_r, frag_left_nxt;
  logic              frag_reject_r, frag_reject_nxt;
  status_t           drop_code_r, drop_code_nxt;
  logic              read_active_r, read_active_nxt;
  logic [SLOT_W-1:0] read_slot_r, read_slot_nxt;
  logic [LEN_W-1:0]  read_pos_r, read_pos_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic [OLEN_W-1:0] out_len_r, out_len_nxt;
  logic        out_last_r, out_last_nxt;

  // table write controls
  logic              tbl_open;
  logic              tbl_len_we;
  logic [SLOT_W-1:0] tbl_slot;
  logic [LEN_W-1:0]  tbl_len;
  logic              grp_free;
  logic [KEY_W-1:0]  grp_val;

  key_res_t kres;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_rdata;

  logic              hit, has_free;
  logic [SLOT_W-1:0] hit_idx, free_idx;
  logic [SLOT_W-1:0] sel;
  logic [LEN_W-1:0]  cur_len;
  logic              in_acc;

  frb_key_unit u_key (
    .clk   (clk),
    .src   (src_r),
    .dest  (dest_r),
    .seqno (seqno_r),
    .link  (link_r),
    .res   (kres)
  );

  frb_payload_ram #(.ADDR_W(ADDR_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (dbyte_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_len_r, out_byte_r, out_status_r};

  // parallel match and first free slot
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!hit && slot_valid_r[i] && slot_key_r[i] == kres.key) begin
        hit = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!has_free && !slot_valid_r[i]) begin
        has_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    frag_active_nxt = frag_active_r;
    frag_slot_nxt   = frag_slot_r;
    frag_left_nxt   = frag_left_r;
    frag_reject_nxt = frag_reject_r;
    drop_code_nxt   = drop_code_r;
    read_active_nxt = read_active_r;
    read_slot_nxt   = read_slot_r;
    read_pos_nxt    = read_pos_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_byte_nxt    = out_byte_r;
    out_len_nxt     = out_len_r;
    out_last_nxt    = out_last_r;
    tbl_open   = 1'b0;
    tbl_len_we = 1'b0;
    tbl_slot   = '0;
    tbl_len    = '0;
    grp_free   = 1'b0;
    grp_val    = kres.group;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = '0;
    ram_raddr  = {read_slot_r, BYTE_W'(read_pos_r)};
    sel        = '0;
    cur_len    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_KEY1;
        end
      end
      S_KEY1: state_nxt = S_KEY2;
      S_KEY2: state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (!op_r) begin
          read_active_nxt = 1'b0;
          out_byte_nxt = '0;
          out_len_nxt  = '0;
          if (frag_active_r) begin
            frag_left_nxt   = frag_left_r - 1'b1;
            frag_active_nxt = (frag_left_r != FLEN_W'(1));
            out_last_nxt    = !frag_active_nxt;
            out_valid_nxt   = 1'b1;
            if (frag_reject_r) begin
              out_status_nxt = drop_code_r;
            end else begin
              sel = frag_slot_r;
              cur_len = slot_len_r[frag_slot_r];
              if (cur_len >= MSG_MAX) begin
                out_status_nxt = ST_MSG_FULL;
              end else begin
                out_status_nxt = ST_STORED;
                ram_we = 1'b1;
                ram_waddr = {sel, BYTE_W'(cur_len)};
                tbl_len_we = 1'b1;
                tbl_slot = sel;
                tbl_len = cur_len + 1'b1;
              end
            end
          end else begin
            frag_active_nxt = flen_r > FLEN_W'(1);
            frag_left_nxt   = (flen_r > FLEN_W'(1)) ? flen_r - 1'b1 : '0;
            frag_reject_nxt = 1'b0;
            out_last_nxt    = !frag_active_nxt;
            out_valid_nxt   = 1'b1;
            if (flen_r > max_payload_r) begin
              frag_reject_nxt = 1'b1;
              drop_code_nxt   = ST_REJECTED;
              out_status_nxt  = ST_REJECTED;
            end else if (!hit && !has_free) begin
              frag_reject_nxt = 1'b1;
              drop_code_nxt   = ST_TABLE_FULL;
              out_status_nxt  = ST_TABLE_FULL;
            end else begin
              sel = hit ? hit_idx : free_idx;
              cur_len = hit ? slot_len_r[hit_idx] : '0;
              tbl_open = !hit;
              tbl_slot = sel;
              tbl_len_we = !hit;
              tbl_len = '0;
              frag_slot_nxt = sel;
              out_status_nxt = ST_STORED;
              if (flen_r != '0) begin
                if (cur_len >= MSG_MAX) begin
                  out_status_nxt = ST_MSG_FULL;
                end else begin
                  ram_we = 1'b1;
                  ram_waddr = {sel, BYTE_W'(cur_len)};
                  tbl_len_we = 1'b1;
                  tbl_len = cur_len + 1'b1;
                end
              end
            end
          end
        end else begin
          frag_active_nxt = 1'b0;
          if (read_active_r) begin
            state_nxt = S_RD;
          end else if (!hit || slot_len_r[hit_idx] == '0) begin
            grp_free       = 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = hit ? ST_BYTE_READ : ST_NOT_FOUND;
            out_byte_nxt   = '0;
            out_len_nxt    = '0;
            out_last_nxt   = 1'b1;
          end else begin
            read_slot_nxt   = hit_idx;
            read_pos_nxt    = '0;
            read_active_nxt = 1'b1;
            state_nxt       = S_RD;
          end
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_RDD;
      end
      S_RDD: begin
        state_nxt      = S_IDLE;
        cur_len        = slot_len_r[read_slot_r];
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_BYTE_READ;
        out_byte_nxt   = ram_rdata;
        out_len_nxt    = OLEN_W'(cur_len);
        out_last_nxt   = 1'b0;
        read_pos_nxt   = read_pos_r + 1'b1;
        if (read_pos_nxt >= cur_len) begin
          read_active_nxt = 1'b0;
          read_pos_nxt    = '0;
          out_last_nxt    = 1'b1;
          grp_free        = 1'b1;
          grp_val         = slot_group_r[read_slot_r];
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    if (grp_free) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid_r[i] && slot_group_r[i] == grp_val) begin
          slot_valid_nxt[i] = 1'b0;
        end
      end
    end
    if (tbl_open) begin
      slot_valid_nxt[tbl_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      max_payload_r <= MAX_PAYLOAD_RST;
      slot_valid_r  <= '0;
      frag_active_r <= 1'b0;
      frag_slot_r   <= '0;
      frag_left_r   <= '0;
      frag_reject_r <= 1'b0;
      drop_code_r   <= ST_STORED;
      read_active_r <= 1'b0;
      read_slot_r   <= '0;
      read_pos_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        max_payload_r <= cfg_data;
      end
      slot_valid_r  <= slot_valid_nxt;
      frag_active_r <= frag_active_nxt;
      frag_slot_r   <= frag_slot_nxt;
      frag_left_r   <= frag_left_nxt;
      frag_reject_r <= frag_reject_nxt;
      drop_code_r   <= drop_code_nxt;
      read_active_r <= read_active_nxt;
      read_slot_r   <= read_slot_nxt;
      read_pos_r    <= read_pos_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_tuser;
      src_r   <= in_tdata[15:0];
      dest_r  <= in_tdata[31:16];
      seqno_r <= in_tdata[47:32];
      link_r  <= in_tdata[52:48];
      flen_r  <= in_tdata[63:53];
      dbyte_r <= in_tdata[71:64];
    end
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
    if (tbl_open) begin
      slot_key_r[tbl_slot]   <= kres.key;
      slot_group_r[tbl_slot] <= kres.group;
    end
    if (tbl_len_we) begin
      slot_len_r[tbl_slot] <= tbl_len;
    end
  end

  a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_tready)
    else $error("item accepted while result pending");

  a_exec_after_key: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> $past(state_r) == S_KEY2)
    else $error("table step without key pipeline");

  a_read_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    read_active_r |-> slot_valid_r[read_slot_r])
    else $error("read from freed slot");

  a_frag_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (frag_active_r && !frag_reject_r) |-> slot_valid_r[frag_slot_r])
    else $error("append into freed slot");

endmodule
`default_nettype wire
